// File: sv/cba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_pkg
// Shared widths, codes and word types of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Field widths fixed by the request and result words
  localparam int FILE_ID_W = 8;
  localparam int START_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int STATUS_W  = 2;
  // start + count is at most 1023 + 2047
  localparam int END_W     = 12;

  // Bitmap word geometry
  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;
  localparam int WIDX_W    = END_W - WORD_SH;

  // Default sizes
  localparam int DISK_BLOCKS_DEF = 1024;
  localparam int FILE_SLOTS_DEF  = 256;

  // Commands
  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CANNOT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Bitmap walk operations
  localparam logic BM_OP_CHECK = 1'b0;
  localparam logic BM_OP_MARK  = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [FILE_ID_W-1:0] file_id;
    logic [START_W-1:0]   start_block;
    logic [COUNT_W-1:0]   block_count;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  found_start;
    logic [COUNT_W-1:0]  found_count;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } ft_entry_t;

  typedef struct packed {
    logic                 re;
    logic                 we;
    logic [FILE_ID_W-1:0] file_id;
    ft_entry_t            entry;
  } ft_req_t;

  typedef struct packed {
    logic      ready;
    ft_entry_t entry;
  } ft_rsp_t;

  typedef struct packed {
    logic               go;
    logic               op;
    logic [START_W-1:0] first;
    logic [END_W-1:0]   last;
  } bm_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
  } bm_rsp_t;

endpackage
`default_nettype wire

// File: sv/cba_bitmap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_bitmap
// Block-used bitmap in 32-bit memory words; walks a block range to check it
// for used blocks or to mark it used, one word read per cycle.
// ----------------------------------------------------------------------------
module cba_bitmap
  import cba_pkg::*;
#(
  parameter int DISK_BLOCKS = DISK_BLOCKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire bm_req_t req,
  output bm_rsp_t   rsp
);

  localparam int BM_WORDS = (DISK_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BM_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
  localparam int WC_W     = ((BM_AW > WIDX_W) ? BM_AW : WIDX_W) + 1;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic [WORD_BITS-1:0] mem [BM_WORDS];
  logic [WORD_BITS-1:0] q_r;

  logic                 state_r, state_nxt;
  logic                 op_r, op_nxt;
  logic [WORD_SH-1:0]   fw_r, fw_nxt;
  logic [WIDX_W-1:0]    lw_r, lw_nxt;
  logic [WORD_SH-1:0]   lo_r, lo_nxt;
  logic [WORD_SH-1:0]   hi_r, hi_nxt;
  logic [WC_W-1:0]      wc_r, wc_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic [WC_W-1:0]      p_w_r, p_w_nxt;
  logic                 clr_busy_r;
  logic [BM_AW-1:0]     clr_idx_r;

  logic                 issue;
  logic                 p_last;
  logic [WORD_SH-1:0]   lo, hi;
  logic [WORD_BITS-1:0] mask;
  logic                 hit;
  logic                 mark_we;
  logic                 we;
  logic [BM_AW-1:0]     waddr;
  logic [WORD_BITS-1:0] wdata;

  assign issue  = (state_r == B_RUN) && (wc_r <= WC_W'(lw_r));
  assign p_last = (p_w_r == WC_W'(lw_r));
  assign lo     = (p_w_r == WC_W'(fw_r)) ? lo_r : '0;
  assign hi     = p_last ? hi_r : '1;
  assign mask   = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
  assign hit    = |(q_r & mask);

  assign mark_we = (state_r == B_RUN) && p_vld_r && (op_r == BM_OP_MARK);
  assign we      = clr_busy_r || mark_we;
  assign waddr   = clr_busy_r ? clr_idx_r : p_w_r[BM_AW-1:0];
  assign wdata   = clr_busy_r ? '0 : (q_r | mask);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    fw_nxt    = fw_r;
    lw_nxt    = lw_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    wc_nxt    = wc_r;
    p_vld_nxt = issue;
    p_w_nxt   = wc_r;
    rsp.ready = !clr_busy_r && (state_r == B_IDLE);
    rsp.done  = 1'b0;
    rsp.hit   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (req.go) begin
          state_nxt = B_RUN;
          op_nxt    = req.op;
          fw_nxt    = req.first[START_W-1:WORD_SH];
          lw_nxt    = req.last[END_W-1:WORD_SH];
          lo_nxt    = req.first[WORD_SH-1:0];
          hi_nxt    = req.last[WORD_SH-1:0];
          wc_nxt    = WC_W'(req.first[START_W-1:WORD_SH]);
        end
      end
      B_RUN: begin
        if (issue) begin
          wc_nxt = wc_r + WC_W'(1);
        end
        if (p_vld_r) begin
          if (op_r == BM_OP_CHECK && hit) begin
            // drop the rest of the walk
            rsp.done  = 1'b1;
            rsp.hit   = 1'b1;
            state_nxt = B_IDLE;
          end else if (p_last) begin
            rsp.done  = 1'b1;
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      p_vld_r    <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= p_vld_nxt;
      if (clr_busy_r) begin
        if (clr_idx_r == BM_AW'(BM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + BM_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    fw_r  <= fw_nxt;
    lw_r  <= lw_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    wc_r  <= wc_nxt;
    p_w_r <= p_w_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      q_r <= mem[wc_r[BM_AW-1:0]];
    end
  end

endmodule
`default_nettype wire

// File: sv/cba_ftab.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_ftab
// File table memory indexed by file id: valid flag, start and count per slot.
// ----------------------------------------------------------------------------
module cba_ftab
  import cba_pkg::*;
#(
  parameter int FILE_SLOTS = FILE_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ft_req_t req,
  output ft_rsp_t   rsp
);

  localparam int FS_AW = $clog2(FILE_SLOTS);
  localparam int IDX_W = (FS_AW > FILE_ID_W) ? FS_AW : FILE_ID_W;

  ft_entry_t        mem [FILE_SLOTS];
  ft_entry_t        q_r;
  logic             clr_busy_r;
  logic [FS_AW-1:0] clr_idx_r;

  logic [IDX_W-1:0] id_ext;
  logic [FS_AW-1:0] idx;

  assign id_ext = IDX_W'(req.file_id);
  assign idx    = id_ext[FS_AW-1:0];

  assign rsp.ready = !clr_busy_r;
  assign rsp.entry = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == FS_AW'(FILE_SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + FS_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.we) begin
      mem[idx] <= req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      q_r <= mem[idx];
    end
  end

endmodule
`default_nettype wire

// File: sv/contiguous_block_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core
// Contiguous disk block allocator: used-block bitmap plus file extent table.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall / in_word carry one request word: allocate a range
//   (cmd 0: file id, start block, block count) or look up a file (cmd 1).
//   out_valid / out_stall / out_word return exactly one result word per
//   request. A word moves on a rising edge with valid high and stall low.
// Order of work (one request in work at a time):
//   Requests decided on accept (bad id, zero count, range past the disk)
//   go straight to the done state; lookups first read the file table.
//   An allocate walks the bitmap one 32-bit memory word per cycle, twice:
//   a check pass over the words the range touches, a restart of the walk,
//   and a mark pass that sets the bits. A used block ends the check pass
//   early. A new request is taken only once the result of the last one
//   has been loaded into the output register.
// Reset: rst_n clears control state, then both memories are swept clear one
//   entry per cycle while in_stall is high.
// Stall: the result waits in an output register while out_stall is high;
//   the next request is worked on meanwhile and its result waits for it.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core
  import cba_pkg::*;
#(
  parameter int DISK_BLOCKS = DISK_BLOCKS_DEF,
  parameter int FILE_SLOTS  = FILE_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  // Compare widths wide enough for the parameter limits
  localparam int DB_W  = $clog2(DISK_BLOCKS + 1);
  localparam int CMP_W = (DB_W > END_W) ? DB_W : END_W;
  localparam int FS_W  = $clog2(FILE_SLOTS + 1);
  localparam int IDC_W = (FS_W > FILE_ID_W) ? FS_W : FILE_ID_W + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;
  localparam logic [2:0] S_MSTART = 3'd6;

  logic [2:0] state_r, state_nxt;
  in_word_t   req_r, req_nxt;
  out_word_t  res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  bm_req_t    bm_req;
  bm_rsp_t    bm_rsp;
  ft_req_t    ft_req;
  ft_rsp_t    ft_rsp;

  in_word_t         src;
  logic             accept;
  logic [END_W-1:0] end_sum;
  logic             id_ok;
  logic             fits;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Decode from the incoming word while idle, else from the held request
  assign src     = (state_r == S_IDLE) ? in_word : req_r;
  assign end_sum = END_W'(src.start_block) + END_W'(src.block_count);
  assign id_ok   = IDC_W'(src.file_id) < IDC_W'(FILE_SLOTS);
  assign fits    = CMP_W'(end_sum) <= CMP_W'(DISK_BLOCKS);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    // drop the result once taken
    out_valid_nxt = out_valid_r && out_stall;

    bm_req       = '0;
    bm_req.first = src.start_block;
    bm_req.last  = end_sum - END_W'(1);
    ft_req         = '0;
    ft_req.file_id = src.file_id;

    case (state_r)
      S_CLEAR: begin
        // hold until both memories are swept
        if (bm_rsp.ready && ft_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_word;
          res_nxt = '0;
          if (in_word.cmd == CMD_LOOKUP) begin
            if (id_ok) begin
              ft_req.re = 1'b1;
              state_nxt = S_LOOK;
            end else begin
              res_nxt.status = ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          end else if (!id_ok) begin
            res_nxt.status = ST_CANNOT;
            state_nxt      = S_DONE;
          end else if (in_word.block_count == '0) begin
            // zero count: record the entry, mark nothing
            ft_req.we          = 1'b1;
            ft_req.entry.valid = 1'b1;
            ft_req.entry.start = in_word.start_block;
            ft_req.entry.count = '0;
            res_nxt.status     = ST_ALLOCATED;
            state_nxt          = S_DONE;
          end else if (!fits) begin
            res_nxt.status = ST_CANNOT;
            state_nxt      = S_DONE;
          end else begin
            bm_req.go = 1'b1;
            bm_req.op = BM_OP_CHECK;
            state_nxt = S_CHECK;
          end
        end
      end
      S_LOOK: begin
        if (ft_rsp.entry.valid) begin
          res_nxt.status      = ST_FOUND;
          res_nxt.found_start = ft_rsp.entry.start;
          res_nxt.found_count = ft_rsp.entry.count;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
        state_nxt = S_DONE;
      end
      S_CHECK: begin
        if (bm_rsp.done) begin
          if (bm_rsp.hit) begin
            res_nxt.status = ST_CANNOT;
            state_nxt      = S_DONE;
          end else begin
            // range is free: restart the walk once the bitmap is idle
            state_nxt = S_MSTART;
          end
        end
      end
      S_MSTART: begin
        // walk the range again and set the bits
        if (bm_rsp.ready) begin
          bm_req.go = 1'b1;
          bm_req.op = BM_OP_MARK;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (bm_rsp.done) begin
          // overwrite any earlier extent; its blocks stay used
          ft_req.we          = 1'b1;
          ft_req.entry.valid = 1'b1;
          ft_req.entry.start = req_r.start_block;
          ft_req.entry.count = req_r.block_count;
          res_nxt.status     = ST_ALLOCATED;
          state_nxt          = S_DONE;
        end
      end
      S_DONE: begin
        // advance once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  cba_bitmap #(
    .DISK_BLOCKS(DISK_BLOCKS)
  ) u_bitmap (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (bm_req),
    .rsp  (bm_rsp)
  );

  cba_ftab #(
    .FILE_SLOTS(FILE_SLOTS)
  ) u_ftab (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ft_req),
    .rsp  (ft_rsp)
  );

`ifndef NO_ASSERTIONS
  a_bm_go_ready : assert property (@(posedge clk) disable iff (!rst_n)
    bm_req.go |-> bm_rsp.ready)
    else $error("bitmap walk started while bitmap busy");

  a_check_hit_fails : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) && bm_rsp.done && bm_rsp.hit
      |=> (state_r == S_DONE) && (res_r.status == ST_CANNOT))
    else $error("used block in range did not fail the allocate");

  a_clear_stalls : assert property (@(posedge clk) disable iff (!rst_n)
    (!bm_rsp.ready || !ft_rsp.ready) && (state_r != S_IDLE) |-> in_stall)
    else $error("request taken during memory sweep");

  a_done_delivers : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !(out_valid_r && out_stall)
      |=> out_valid && (state_r == S_IDLE))
    else $error("finished result not moved to output register");
`endif

endmodule
`default_nettype wire
